/* rtl/signed_restoring_divider_core_defines.svh */
`ifndef SIGNED_RESTORING_DIVIDER_CORE_DEFINES_SVH
`define SIGNED_RESTORING_DIVIDER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define SRD_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst.
`define SRD_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

/* rtl/srd_pkg.sv */
package srd_pkg;

  localparam int WIDTH = 32;

  // Payload carried down the chain of division cells.
  typedef struct packed {
    logic [WIDTH-1:0] rem;    // partial remainder
    logic [WIDTH-1:0] acc;    // dividend bits still to go, quotient bits shifted in below
    logic [WIDTH-1:0] dvs;    // divisor magnitude
    logic             neg_q;  // negate quotient at the end
    logic             neg_r;  // negate remainder at the end
    logic             dbz;    // divisor was zero
  } item_t;

endpackage

/* rtl/signed_restoring_divider_core.sv */
// Signed 32-bit divider built as a pipelined chain of restoring-division cells.
// Takes one operand pair per cycle while in_ready is high and returns the
// quotient truncated toward zero and the remainder with the sign of the
// dividend, as C does. A zero divisor returns all ones on both results with
// divide_by_zero set; the most negative value divided by -1 wraps to the most
// negative value with a zero remainder. Throughput is one transfer per clock
// while out_ready stays high. An item passes 34 registers: one sign-stripping
// stage, 32 cells each resolving one quotient bit with one 33-bit trial
// subtract, and one sign-restoring output register. The first of these loads
// on the input transfer edge. Each stage holds its item while the next is
// full, so bubbles fill up under back-pressure and the input keeps taking
// transfers until every stage is occupied.
`include "signed_restoring_divider_core_defines.svh"

module signed_restoring_divider_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [srd_pkg::WIDTH-1:0] dividend,
  input  logic [srd_pkg::WIDTH-1:0] divisor,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [srd_pkg::WIDTH-1:0] quotient,
  output logic [srd_pkg::WIDTH-1:0] remainder,
  output logic                      divide_by_zero
);

  // Link k feeds cell k; link 0 comes from the sign-stripping stage and
  // link WIDTH goes to the output stage.
  logic           link_valid [0:srd_pkg::WIDTH];
  logic           link_ready [0:srd_pkg::WIDTH];
  srd_pkg::item_t link_item  [0:srd_pkg::WIDTH];

  // Strip signs and flag a zero divisor.
  srd_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dividend  (dividend),
    .divisor   (divisor),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_item  (link_item[0])
  );

  // One quotient bit per cell, most significant first.
  for (genvar k = 0; k < srd_pkg::WIDTH; k++) begin : g_cell
    srd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[k]),
      .in_ready  (link_ready[k]),
      .in_item   (link_item[k]),
      .out_valid (link_valid[k+1]),
      .out_ready (link_ready[k+1]),
      .out_item  (link_item[k+1])
    );
  end

  // Restore signs and hold the result until the transfer completes.
  srd_fix u_fix (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (link_valid[srd_pkg::WIDTH]),
    .in_ready       (link_ready[srd_pkg::WIDTH]),
    .in_item        (link_item[srd_pkg::WIDTH]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

  // An input transfer must land in the first stage.
  `SRD_ASSERT_NEXT(a_in_lands, in_valid && in_ready, link_valid[0], "input transfer lost")

  // A non-zero divisor must leave a non-zero magnitude.
  `SRD_ASSERT_NOW(a_dvs_nonzero, link_valid[0] && !link_item[0].dbz,
    link_item[0].dvs != '0, "zero magnitude for non-zero divisor")

  // Remainder magnitude below divisor magnitude after the last cell.
  `SRD_ASSERT_NOW(a_rem_bound, link_valid[srd_pkg::WIDTH] && !link_item[srd_pkg::WIDTH].dbz,
    link_item[srd_pkg::WIDTH].rem < link_item[srd_pkg::WIDTH].dvs, "remainder not reduced")

  // Divide by zero gives all ones on both results.
  `SRD_ASSERT_NOW(a_dbz_ones, out_valid && divide_by_zero,
    (quotient == '1) && (remainder == '1), "divide-by-zero results not all ones")

endmodule

/* rtl/srd_prep.sv */
module srd_prep (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [srd_pkg::WIDTH-1:0]   dividend,
  input  logic [srd_pkg::WIDTH-1:0]   divisor,
  output logic                        out_valid,
  input  logic                        out_ready,
  output srd_pkg::item_t              out_item
);

  logic                      valid;
  srd_pkg::item_t            item;
  srd_pkg::item_t            item_next;
  logic                      a_neg;
  logic                      b_neg;

  assign a_neg    = dividend[srd_pkg::WIDTH-1];
  assign b_neg    = divisor[srd_pkg::WIDTH-1];
  assign in_ready = !valid || out_ready;

  // Strip signs; magnitudes are unsigned so the most negative value stays exact.
  always_comb begin
    item_next.rem   = '0;
    item_next.acc   = a_neg ? (~dividend + 1'b1) : dividend;
    item_next.dvs   = b_neg ? (~divisor + 1'b1) : divisor;
    item_next.neg_q = a_neg ^ b_neg;
    item_next.neg_r = a_neg;
    item_next.dbz   = (divisor == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

/* rtl/srd_cell.sv */
module srd_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  srd_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output srd_pkg::item_t out_item
);

  logic                    valid;
  srd_pkg::item_t          item;
  srd_pkg::item_t          item_next;
  logic [srd_pkg::WIDTH:0] shifted;
  logic [srd_pkg::WIDTH:0] diff;
  logic                    fits;

  assign in_ready = !valid || out_ready;

  // One restoring step: shift in the next dividend bit, trial subtract, keep on no borrow.
  always_comb begin
    shifted         = {in_item.rem, in_item.acc[srd_pkg::WIDTH-1]};
    diff            = shifted - {1'b0, in_item.dvs};
    fits            = !diff[srd_pkg::WIDTH];
    item_next       = in_item;
    item_next.rem   = fits ? diff[srd_pkg::WIDTH-1:0] : shifted[srd_pkg::WIDTH-1:0];
    item_next.acc   = {in_item.acc[srd_pkg::WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

/* rtl/srd_fix.sv */
module srd_fix (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  srd_pkg::item_t            in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [srd_pkg::WIDTH-1:0] quotient,
  output logic [srd_pkg::WIDTH-1:0] remainder,
  output logic                      divide_by_zero
);

  logic                      valid;
  logic [srd_pkg::WIDTH-1:0] quo_next;
  logic [srd_pkg::WIDTH-1:0] rem_next;

  assign in_ready = !valid || out_ready;

  // Restore signs; a zero divisor forces all ones on both results.
  always_comb begin
    quo_next = in_item.neg_q ? (~in_item.acc + 1'b1) : in_item.acc;
    rem_next = in_item.neg_r ? (~in_item.rem + 1'b1) : in_item.rem;
    if (in_item.dbz) begin
      quo_next = '1;
      rem_next = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      quotient       <= quo_next;
      remainder      <= rem_next;
      divide_by_zero <= in_item.dbz;
    end
  end

  assign out_valid = valid;

endmodule
